// ===== hw/rtl/lsc_pkg.sv =====
// Shared widths, register codes and pipeline types of the line segment clipper.
package lsc_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int MAG_BITS   = COORD_BITS;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int QUO_BITS   = FRAC_BITS + 1;
    localparam int T_BITS     = FRAC_BITS + 2;
    localparam int PROD_BITS  = MAG_BITS + QUO_BITS;
    localparam int NUM_EDGES  = 4;
    localparam int NUM_CELLS  = QUO_BITS;

    localparam logic [COORD_BITS-1:0] WIN_LEFT_RST   = COORD_BITS'(150);
    localparam logic [COORD_BITS-1:0] WIN_TOP_RST    = COORD_BITS'(100);
    localparam logic [COORD_BITS-1:0] WIN_RIGHT_RST  = COORD_BITS'(500);
    localparam logic [COORD_BITS-1:0] WIN_BOTTOM_RST = COORD_BITS'(350);

    typedef enum logic [1:0] {
        REG_WIN_LEFT   = 2'd0,
        REG_WIN_TOP    = 2'd1,
        REG_WIN_RIGHT  = 2'd2,
        REG_WIN_BOTTOM = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [MAG_BITS:0]   rem;
        logic [MAG_BITS-1:0] den;
        logic [QUO_BITS-1:0] quo;
        logic                sat;
        logic                entry;
        logic                leave;
        logic                rej;
    } lane_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic signed [COORD_BITS-1:0] x2;
        logic signed [COORD_BITS-1:0] y2;
    } seg_t;

endpackage

// ===== hw/rtl/line_segment_clipper.sv =====
// Top level of the line segment clipper: edge setup, division chain, bounds, interpolation.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  input    | in_valid/in_ready  | start_x, start_y, end_x, end_y
//  output   | out_valid/out_ready| visible, clip_start_x/y, clip_end_x/y
//  config   | wr_en              | wr_index, wr_data
//
// One segment per cycle while out_ready does not stall the pipeline; the chain of
// FRAC_BITS + 1 division cells yields one quotient bit per cell.
// Reset clears the valid bits and loads the default window.
// Each stage holds only while the one after it is full and stalled.
module line_segment_clipper
    import lsc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [1:0]                   wr_index,
    input  logic [COORD_BITS-1:0]        wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         visible,
    output logic signed [COORD_BITS-1:0] clip_start_x,
    output logic signed [COORD_BITS-1:0] clip_start_y,
    output logic signed [COORD_BITS-1:0] clip_end_x,
    output logic signed [COORD_BITS-1:0] clip_end_y
);

    localparam int STG_B = NUM_CELLS + 1;
    localparam int STG_M = NUM_CELLS + 2;
    localparam int STG_O = NUM_CELLS + 3;
    localparam int NSTG  = NUM_CELLS + 4;

    logic [COORD_BITS-1:0] win_left_reg, win_top_reg, win_right_reg, win_bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= WIN_LEFT_RST;
            win_top_reg    <= WIN_TOP_RST;
            win_right_reg  <= WIN_RIGHT_RST;
            win_bottom_reg <= WIN_BOTTOM_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_index_t'(wr_index))
                REG_WIN_LEFT:   win_left_reg   <= wr_data;
                REG_WIN_TOP:    win_top_reg    <= wr_data;
                REG_WIN_RIGHT:  win_right_reg  <= wr_data;
                REG_WIN_BOTTOM: win_bottom_reg <= wr_data;
            endcase
        end
    end

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] en;

    assign en[STG_O] = !valid_reg[STG_O] || out_ready;
    genvar gi;
    generate
        for (gi = 0; gi < STG_O; gi++)
        begin : g_en
            assign en[gi] = !valid_reg[gi] || en[gi+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= (i == 0) ? in_valid : valid_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[STG_O];

    // edge setup
    logic signed [DIFF_BITS-1:0] pv [NUM_EDGES];
    logic signed [DIFF_BITS-1:0] qv [NUM_EDGES];
    lane_t                       lane0_next [NUM_EDGES];
    lane_t                       lane0_reg [NUM_EDGES];
    logic [DIFF_BITS-1:0]        pa, qa;

    always_comb
    begin
        pv[0] = DIFF_BITS'(start_x) - DIFF_BITS'(end_x);
        qv[0] = DIFF_BITS'(start_x) - DIFF_BITS'($signed(win_left_reg));
        pv[1] = DIFF_BITS'(end_x) - DIFF_BITS'(start_x);
        qv[1] = DIFF_BITS'($signed(win_right_reg)) - DIFF_BITS'(start_x);
        pv[2] = DIFF_BITS'(start_y) - DIFF_BITS'(end_y);
        qv[2] = DIFF_BITS'(start_y) - DIFF_BITS'($signed(win_top_reg));
        pv[3] = DIFF_BITS'(end_y) - DIFF_BITS'(start_y);
        qv[3] = DIFF_BITS'($signed(win_bottom_reg)) - DIFF_BITS'(start_y);
        pa = '0;
        qa = '0;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            pa = pv[e][DIFF_BITS-1] ? -pv[e] : pv[e];
            qa = qv[e][DIFF_BITS-1] ? -qv[e] : qv[e];
            lane0_next[e].rem   = {1'b0, qa[MAG_BITS-1:0]};
            lane0_next[e].den   = pa[MAG_BITS-1:0];
            lane0_next[e].quo   = '0;
            lane0_next[e].sat   = {1'b0, qa[MAG_BITS-1:0]} >= {pa[MAG_BITS-1:0], 1'b0};
            lane0_next[e].entry = pv[e][DIFF_BITS-1] && (qv[e][DIFF_BITS-1] || qv[e] == '0);
            lane0_next[e].leave = !pv[e][DIFF_BITS-1] && pv[e] != '0 && !qv[e][DIFF_BITS-1];
            lane0_next[e].rej   = !pv[e][DIFF_BITS-1] && qv[e][DIFF_BITS-1];
        end
    end

    seg_t seg_reg [STG_B+1];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            seg_reg[0] <= '{x1: start_x, y1: start_y, x2: end_x, y2: end_y};
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                lane0_reg[e] <= lane0_next[e];
            end
        end
        for (int k = 1; k <= STG_B; k++)
        begin
            if (en[k])
            begin
                seg_reg[k] <= seg_reg[k-1];
            end
        end
    end

    // division chain
    lane_t lane_w [NUM_CELLS+1][NUM_EDGES];

    genvar gk, ge;
    generate
        for (ge = 0; ge < NUM_EDGES; ge++)
        begin : g_head
            assign lane_w[0][ge] = lane0_reg[ge];
        end
        for (gk = 0; gk < NUM_CELLS; gk++)
        begin : g_cell
            for (ge = 0; ge < NUM_EDGES; ge++)
            begin : g_edge
                lsc_div_cell u_cell (
                    .clk      (clk),
                    .en       (en[gk+1]),
                    .lane_in  (lane_w[gk][ge]),
                    .lane_out (lane_w[gk+1][ge])
                );
            end
        end
    endgenerate

    // entry and exit bounds
    logic [T_BITS-1:0]   tl, t0c, t1c;
    logic                rejc;
    logic [QUO_BITS-1:0] t0_reg, t1_reg;
    logic                ok_reg;

    always_comb
    begin
        t0c  = '0;
        t1c  = T_BITS'(1) << FRAC_BITS;
        rejc = 1'b0;
        tl   = '0;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            tl = lane_w[NUM_CELLS][e].sat ? (T_BITS'(2) << FRAC_BITS)
                                          : {1'b0, lane_w[NUM_CELLS][e].quo};
            if (lane_w[NUM_CELLS][e].entry && tl > t0c)
            begin
                t0c = tl;
            end
            if (lane_w[NUM_CELLS][e].leave && tl < t1c)
            begin
                t1c = tl;
            end
            rejc = rejc | lane_w[NUM_CELLS][e].rej;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_B])
        begin
            t0_reg <= t0c[QUO_BITS-1:0];
            t1_reg <= t1c[QUO_BITS-1:0];
            ok_reg <= !rejc && (t0c <= t1c);
        end
    end

    // products
    logic signed [DIFF_BITS-1:0] dx, dy;
    logic [DIFF_BITS-1:0]        mxa, mya;
    logic [PROD_BITS-1:0]        prod_reg [NUM_EDGES];
    logic                        dxn_reg, dyn_reg, okm_reg;
    logic signed [COORD_BITS-1:0] ax_reg, ay_reg;

    always_comb
    begin
        dx  = DIFF_BITS'(seg_reg[STG_B].x2) - DIFF_BITS'(seg_reg[STG_B].x1);
        dy  = DIFF_BITS'(seg_reg[STG_B].y2) - DIFF_BITS'(seg_reg[STG_B].y1);
        mxa = dx[DIFF_BITS-1] ? -dx : dx;
        mya = dy[DIFF_BITS-1] ? -dy : dy;
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_M])
        begin
            prod_reg[0] <= PROD_BITS'(mxa[MAG_BITS-1:0]) * PROD_BITS'(t0_reg);
            prod_reg[1] <= PROD_BITS'(mya[MAG_BITS-1:0]) * PROD_BITS'(t0_reg);
            prod_reg[2] <= PROD_BITS'(mxa[MAG_BITS-1:0]) * PROD_BITS'(t1_reg);
            prod_reg[3] <= PROD_BITS'(mya[MAG_BITS-1:0]) * PROD_BITS'(t1_reg);
            dxn_reg     <= dx[DIFF_BITS-1];
            dyn_reg     <= dy[DIFF_BITS-1];
            ax_reg      <= seg_reg[STG_B].x1;
            ay_reg      <= seg_reg[STG_B].y1;
            okm_reg     <= ok_reg;
        end
    end

    // interpolate, truncate toward zero
    logic signed [DIFF_BITS:0]    base [NUM_EDGES];
    logic signed [DIFF_BITS:0]    av;
    logic [DIFF_BITS:0]           ip;
    logic                         fr, dn;
    logic                         vis_reg;
    logic signed [COORD_BITS-1:0] res_reg [NUM_EDGES];

    always_comb
    begin
        av = '0;
        ip = '0;
        fr = 1'b0;
        dn = 1'b0;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            av = (e % 2 == 0) ? (DIFF_BITS+1)'(ax_reg) : (DIFF_BITS+1)'(ay_reg);
            dn = (e % 2 == 0) ? dxn_reg : dyn_reg;
            ip = (DIFF_BITS+1)'(prod_reg[e][PROD_BITS-1:FRAC_BITS]);
            fr = |prod_reg[e][FRAC_BITS-1:0];
            if (!dn)
            begin
                base[e] = av + $signed(ip);
                if (fr && base[e][DIFF_BITS])
                begin
                    base[e] = base[e] + (DIFF_BITS+1)'(1);
                end
            end
            else
            begin
                base[e] = av - $signed(ip);
                if (fr && !base[e][DIFF_BITS] && base[e] != '0)
                begin
                    base[e] = base[e] - (DIFF_BITS+1)'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_O])
        begin
            vis_reg <= okm_reg;
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                res_reg[e] <= okm_reg ? base[e][COORD_BITS-1:0] : '0;
            end
        end
    end

    assign visible      = vis_reg;
    assign clip_start_x = res_reg[0];
    assign clip_start_y = res_reg[1];
    assign clip_end_x   = res_reg[2];
    assign clip_end_y   = res_reg[3];

endmodule

// ===== hw/rtl/lsc_div_cell.sv =====
// One restoring division step for one window edge, registered.
module lsc_div_cell
    import lsc_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  lane_t lane_in,
    output lane_t lane_out
);

    lane_t             lane_reg;
    lane_t             lane_next;
    logic              ge;
    logic [MAG_BITS:0] rs;

    always_comb
    begin
        lane_next = lane_in;
        ge = lane_in.rem >= {1'b0, lane_in.den};
        rs = ge ? (lane_in.rem - {1'b0, lane_in.den}) : lane_in.rem;
        lane_next.rem = {rs[MAG_BITS-1:0], 1'b0};
        lane_next.quo = {lane_in.quo[QUO_BITS-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule
